// ===== hdl/ocf_pkg.sv =====
// shared types and constants of the occurrence capped filter
package ocf_pkg;

  localparam int unsigned DISTINCT_MAX_DEF = 64;
  localparam int unsigned VALUE_W          = 32;
  localparam int unsigned COUNT_W          = 8;
  localparam int unsigned ENTRY_W          = VALUE_W + COUNT_W;
  localparam int unsigned PADDR_W          = 3;
  localparam int unsigned PDATA_W          = 32;

  localparam logic [PADDR_W-1:0] REG_MAX_COUNT_ADDR = 3'd0;
  localparam logic [COUNT_W-1:0] MAX_COUNT_RST      = 8'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

// ===== hdl/ocf_ram.sv =====
// generic single write port, single read port ram with registered read
module ocf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ocf_apb.sv =====
// apb configuration register block holding the occurrence limit
module ocf_apb
  import ocf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [COUNT_W-1:0] max_count_o
);

  logic [COUNT_W-1:0] max_count_q, max_count_d;
  logic               sel_max_count;

  assign sel_max_count = paddr[PADDR_W-1:2] == REG_MAX_COUNT_ADDR[PADDR_W-1:2];
  assign pready        = 1'b1;

  always_comb begin
    max_count_d = max_count_q;
    if (psel && penable && pwrite && pready && sel_max_count) begin
      max_count_d = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= MAX_COUNT_RST;
    end else begin
      max_count_q <= max_count_d;
    end
  end

  assign prdata      = sel_max_count ? {{(PDATA_W-COUNT_W){1'b0}}, max_count_q} : '0;
  assign max_count_o = max_count_q;

endmodule

// ===== hdl/ocf_ctrl.sv =====
// sequencer scanning the value table one entry per cycle through a shared comparator
module ocf_ctrl
  import ocf_pkg::*;
#(
  parameter int unsigned DISTINCT_MAX = DISTINCT_MAX_DEF,
  localparam int unsigned AW          = $clog2(DISTINCT_MAX),
  localparam int unsigned UW          = AW + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COUNT_W-1:0] max_count_i,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [VALUE_W-1:0] s_tdata_i,
  input  logic               s_tlast_i,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [VALUE_W-1:0] m_tdata_o,
  output logic [1:0]         m_tuser_o,
  output logic               m_tlast_o,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [ENTRY_W-1:0] ram_wdata_o,
  output logic [AW-1:0]      ram_raddr_o,
  input  logic [ENTRY_W-1:0] ram_rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic [VALUE_W-1:0] value_q;
  logic               last_q;
  logic [UW-1:0]      idx_q;
  logic               chk_q;
  logic [AW-1:0]      chk_idx_q;
  logic [UW-1:0]      used_q;
  logic               keep_q;
  logic               ovf_q;
  logic               m_valid_q;
  logic [VALUE_W-1:0] m_value_q;
  logic               m_last_q;
  logic               m_keep_q;
  logic               m_ovf_q;

  entry_t             rd_entry;
  entry_t             wr_entry;
  logic [COUNT_W-1:0] limit;
  logic               hit;
  logic               more;
  logic               full;
  logic               decide;
  logic               below;

  assign rd_entry = entry_t'(ram_rdata_i);
  assign limit    = (max_count_i == '0) ? COUNT_W'(1) : max_count_i;
  assign hit      = chk_q && (rd_entry.value == value_q);
  assign more     = idx_q < used_q;
  assign full     = used_q == UW'(DISTINCT_MAX);
  assign decide   = (state_q == ST_SCAN) && (hit || !more);
  assign below    = rd_entry.count < limit;

  always_comb begin
    wr_entry.value = value_q;
    wr_entry.count = hit ? rd_entry.count + COUNT_W'(1) : COUNT_W'(1);
  end

  assign ram_we_o    = decide && (hit ? below : !full);
  assign ram_waddr_o = hit ? chk_idx_q : used_q[AW-1:0];
  assign ram_wdata_o = wr_entry;
  assign ram_raddr_o = idx_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      value_q   <= '0;
      last_q    <= 1'b0;
      idx_q     <= '0;
      chk_q     <= 1'b0;
      chk_idx_q <= '0;
      used_q    <= '0;
      keep_q    <= 1'b0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_value_q <= '0;
      m_last_q  <= 1'b0;
      m_keep_q  <= 1'b0;
      m_ovf_q   <= 1'b0;
    end else begin
      if (m_valid_q && m_tready_i && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            value_q <= s_tdata_i;
            last_q  <= s_tlast_i;
            idx_q   <= '0;
            chk_q   <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (decide) begin
            keep_q  <= hit ? below : 1'b1;
            ovf_q   <= !hit && full;
            chk_q   <= 1'b0;
            state_q <= ST_OUT;
            if (last_q) begin
              used_q <= '0;
            end else if (!hit && !full) begin
              used_q <= used_q + UW'(1);
            end
          end else begin
            chk_q     <= 1'b1;
            chk_idx_q <= idx_q[AW-1:0];
            idx_q     <= idx_q + UW'(1);
          end
        end
        ST_OUT: begin
          if (!m_valid_q || m_tready_i) begin
            m_valid_q <= 1'b1;
            m_value_q <= value_q;
            m_last_q  <= last_q;
            m_keep_q  <= keep_q;
            m_ovf_q   <= ovf_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready_o = state_q == ST_IDLE;
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_value_q;
  assign m_tuser_o  = {m_ovf_q, m_keep_q};
  assign m_tlast_o  = m_last_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(DISTINCT_MAX))
    else $error("table fill count beyond depth");

  a_ovf_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_ovf_q) |-> m_keep_q)
    else $error("overflow result not kept");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == ST_SCAN) && decide)
    else $error("table write outside a decision");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide && last_q) |=> (used_q == '0))
    else $error("last transaction did not clear the table");
`endif

endmodule

// ===== hdl/occurrence_capped_filter.sv =====
// top level of the occurrence capped filter
//
// channel   direction  fields (lowest bit first)
// s_axis    in         tdata: value[31:0]; tlast: last
// m_axis    out        tdata: value_out[31:0]; tuser: keep, overflow; tlast: last_out
// apb       in/out     max_count at byte address 0
//
// an item's time from one accept to the next grows with the table fill count, DISTINCT_MAX worst case,
// set by the table scan: one entry per cycle through the registered ram read port
// a match ends the scan early; s_axis_tready is high only between items
// reset empties the table at once through the fill count, no clearing pass
// a stalled m_axis holds the finished result and the next item waits in the output step
module occurrence_capped_filter
  import ocf_pkg::*;
#(
  parameter int unsigned DISTINCT_MAX = DISTINCT_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [VALUE_W-1:0] s_axis_tdata,   // value[31:0]
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [VALUE_W-1:0] m_axis_tdata,   // value_out[31:0]
  output logic [1:0]         m_axis_tuser,   // keep, overflow
  output logic               m_axis_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned AW = $clog2(DISTINCT_MAX);

  logic [COUNT_W-1:0] max_count;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  ocf_apb u_apb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_count_o (max_count)
  );

  ocf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DISTINCT_MAX)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ocf_ctrl #(
    .DISTINCT_MAX (DISTINCT_MAX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_count_i (max_count),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

// ===== tb/tb_top.sv =====
// testbench for the occurrence capped filter: directed table, random lists, predictor check
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ocf_pkg::*;

  localparam int TABLE_DEPTH = DISTINCT_MAX_DEF;
  localparam int RUN_LIMIT   = 600000;
  localparam int TAIL_CYCLES = TABLE_DEPTH + 16;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_LEN    = 600;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int NO_WRITE    = 0;
  localparam int KEEP_BIT    = 0;
  localparam int OVF_BIT     = 1;

  typedef enum int {KIND_POOL, KIND_FLOOD, KIND_NOISE} list_kind_e;

  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 keep;
    bit                 last;
    bit                 ovf;
  } verdict_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 last;
    int                 cap;
    bit                 typed;
    bit                 keep;
    bit                 ovf;
  } vector_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [VALUE_W-1:0] s_axis_tdata = '0;   // value[31:0]
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [VALUE_W-1:0] m_axis_tdata;        // value_out[31:0]
  logic [1:0]         m_axis_tuser;        // keep, overflow
  logic               m_axis_tlast;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  occurrence_capped_filter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [VALUE_W-1:0] slot_value [TABLE_DEPTH];
  logic [COUNT_W-1:0] slot_count [TABLE_DEPTH];
  bit                 slot_used  [TABLE_DEPTH];
  int                 slots_filled = 0;
  logic [COUNT_W-1:0] cap_limit = MAX_COUNT_RST;

  verdict_t pending_results [$];
  verdict_t head_result;
  int       error_count = 0;
  int       results_seen = 0;
  int       cycle_count = 0;
  int       rx_tick = 0;
  int       hold_left = 0;
  bit       held_once = 1'b0;
  bit       offering = 1'b0;
  int       burst_left = 0;
  int       gap_max = 0;
  int       gap_len;

  function automatic verdict_t occurrence_verdict(logic [VALUE_W-1:0] v, bit last);
    verdict_t           r;
    bit                 found;
    logic [COUNT_W-1:0] lim;
    lim = (cap_limit == '0) ? COUNT_W'(1) : cap_limit;
    r.value = v;
    r.keep  = 1'b0;
    r.last  = last;
    r.ovf   = 1'b0;
    found   = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!found && slot_used[i] && slot_value[i] == v) begin
        found = 1'b1;
        if (slot_count[i] < lim) begin
          slot_count[i] = slot_count[i] + 1'b1;
          r.keep = 1'b1;
        end
      end
    end
    if (!found) begin
      r.keep = 1'b1;
      if (slots_filled < TABLE_DEPTH) begin
        slot_used[slots_filled]  = 1'b1;
        slot_value[slots_filled] = v;
        slot_count[slots_filled] = COUNT_W'(1);
        slots_filled++;
      end else begin
        r.ovf = 1'b1;
      end
    end
    if (last) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_used[i]  = 1'b0;
        slot_count[i] = '0;
      end
      slots_filled = 0;
    end
    return r;
  endfunction

  task automatic offer_item(logic [VALUE_W-1:0] v, bit last, bit typed, bit keep, bit ovf);
    verdict_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = occurrence_verdict(v, last);
    if (typed) begin
      r.keep = keep;
      r.ovf  = ovf;
    end
    pending_results.push_back(r);
    // bursts with random gaps
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap_len > 0) begin
        s_axis_tvalid <= 1'b0;
        offering = 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
  endtask

  task automatic quiesce();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      @(posedge clk_i);
    end
    while (pending_results.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_cap(int v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_COUNT_ADDR;
    pwdata  <= PDATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_limit = COUNT_W'(v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: value %h", m_axis_tdata);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (m_axis_tdata !== head_result.value) begin
          $error("value_out: expected %h, got %h", head_result.value, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser[KEEP_BIT] !== head_result.keep) begin
          $error("keep: expected %0d, got %0d", head_result.keep, m_axis_tuser[KEEP_BIT]);
          error_count++;
        end
        if (m_axis_tuser[OVF_BIT] !== head_result.ovf) begin
          $error("overflow: expected %0d, got %0d", head_result.ovf, m_axis_tuser[OVF_BIT]);
          error_count++;
        end
        if (m_axis_tlast !== head_result.last) begin
          $error("last_out: expected %0d, got %0d", head_result.last, m_axis_tlast);
          error_count++;
        end
      end
    end
    rx_tick++;
    if (!held_once && results_seen >= HOLD_AT) begin
      held_once = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_tick / 700) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ((rx_tick % 7) < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    vector_t            directed [20];
    int                 caps [PHASES];
    int                 list_left;
    list_kind_e         list_kind;
    int                 list_idx;
    int                 list_span;
    int                 pool_size;
    int                 pick;
    logic [VALUE_W-1:0] list_base;
    logic [VALUE_W-1:0] v;

    directed = '{
      '{32'h0000_0000, 1'b0, NO_WRITE, 1'b1, 1'b1, 1'b0},
      '{32'h0000_0000, 1'b0, NO_WRITE, 1'b1, 1'b1, 1'b0},
      // counter at the reset limit
      '{32'h0000_0000, 1'b0, NO_WRITE, 1'b1, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, NO_WRITE, 1'b1, 1'b1, 1'b0},
      '{32'h8000_0000, 1'b0, NO_WRITE, 1'b1, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, NO_WRITE, 1'b1, 1'b1, 1'b0},
      '{32'h8000_0000, 1'b0, NO_WRITE, 1'b1, 1'b1, 1'b0},
      '{32'h8000_0000, 1'b0, NO_WRITE, 1'b1, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, NO_WRITE, 1'b1, 1'b1, 1'b0},
      // table cleared by last
      '{32'h0000_0000, 1'b0, NO_WRITE, 1'b1, 1'b1, 1'b0},
      '{32'h0000_0000, 1'b0, NO_WRITE, 1'b1, 1'b1, 1'b0},
      '{32'h0000_0000, 1'b1, NO_WRITE, 1'b1, 1'b0, 1'b0},
      '{32'h5555_5555, 1'b0, 1,        1'b1, 1'b1, 1'b0},
      '{32'h5555_5555, 1'b0, NO_WRITE, 1'b1, 1'b0, 1'b0},
      '{32'hAAAA_AAAA, 1'b1, NO_WRITE, 1'b1, 1'b1, 1'b0},
      '{32'h0000_0007, 1'b0, 3,        1'b1, 1'b1, 1'b0},
      '{32'h0000_0007, 1'b0, NO_WRITE, 1'b1, 1'b1, 1'b0},
      // limit lowered below the count mid list
      '{32'h0000_0007, 1'b0, 1,        1'b1, 1'b0, 1'b0},
      '{32'h1234_5678, 1'b1, NO_WRITE, 1'b0, 1'b0, 1'b0},
      '{32'h0000_0007, 1'b0, 255,      1'b1, 1'b1, 1'b0}
    };
    caps = '{255, 1, 2, 0, 4, 255, 1, 0};
    list_left = 0;
    list_kind = KIND_POOL;
    list_idx  = 0;
    list_span = 1;
    pool_size = 1;
    list_base = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      if (directed[k].cap != NO_WRITE) begin
        quiesce();
        write_cap(directed[k].cap);
      end
      offer_item(directed[k].value, directed[k].last, directed[k].typed,
                 directed[k].keep, directed[k].ovf);
    end

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      write_cap((caps[p] == 0) ? $urandom_range(1, 255) : caps[p]);
      gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 6 : 20);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (list_left == 0) begin
          pick = $urandom_range(0, 9);
          list_idx = 0;
          case ($urandom_range(0, 2))
            0: list_base = $urandom();
            1: list_base = 32'h7FFF_FFFC;
            default: list_base = 32'hFFFF_FFFC;
          endcase
          if (pick == 0) begin
            // more distinct values than the table holds
            list_kind = KIND_FLOOD;
            list_span = TABLE_DEPTH + $urandom_range(1, 8);
            list_left = list_span + $urandom_range(4, 16);
          end else if (pick == 1) begin
            list_kind = KIND_NOISE;
            list_left = $urandom_range(1, 6);
          end else begin
            list_kind = KIND_POOL;
            pool_size = $urandom_range(1, 10);
            list_left = $urandom_range(1, 40);
          end
        end
        case (list_kind)
          KIND_FLOOD: v = (list_idx < list_span) ? list_base + list_idx :
                          list_base + $urandom_range(0, list_span - 1);
          KIND_NOISE: v = $urandom();
          default:    v = list_base + $urandom_range(0, pool_size - 1);
        endcase
        list_idx++;
        list_left--;
        offer_item(v, list_left == 0, 1'b0, 1'b0, 1'b0);
      end
    end

    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
